>>> rtl/mrf_pkg.sv
// ----------------------------------------------------------------------------
// mrf_pkg
// shared types, codes and the crc helper for the modbus rtu request framer
// ----------------------------------------------------------------------------
package mrf_pkg;

  // request kind as carried on the func field
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_READ  = 1'b1;

  // modbus function codes
  localparam logic [7:0] CODE_WRITE = 8'h06;
  localparam logic [7:0] CODE_READ  = 8'h03;

  // register count sent by a read request
  localparam logic [15:0] READ_COUNT = 16'h0001;

  // crc-16/modbus, reflected
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // frame layout
  localparam int FRAME_LEN = 8;
  localparam int BODY_LEN  = 6;
  localparam int IDX_W     = $clog2(FRAME_LEN);

  localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(BODY_LEN);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(FRAME_LEN - 1);

  // default depth of the request queue
  localparam int QUEUE_DEPTH = 2;

  // first six frame bytes, transmit order from msb down
  typedef struct packed {
    logic [7:0]  slave_addr;
    logic [7:0]  code;
    logic [15:0] reg_addr;
    logic [15:0] word;
  } mrf_body_t;

  localparam int BODY_W = $bits(mrf_body_t);

  // front to queue
  typedef struct packed {
    logic      valid;
    mrf_body_t body;
  } mrf_push_t;

  // queue head to back
  typedef struct packed {
    logic      valid;
    mrf_body_t body;
  } mrf_head_t;

  // one byte through the crc, lsb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/mrf_req_if.sv
// ----------------------------------------------------------------------------
// mrf_req_if
// request channel: valid/ready with the request fields
// ----------------------------------------------------------------------------
interface mrf_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  slave_addr;
  logic [15:0] reg_addr;
  logic [15:0] reg_value;

  modport source (output valid, output func, output slave_addr,
                  output reg_addr, output reg_value, input ready);
  modport sink   (input valid, input func, input slave_addr,
                  input reg_addr, input reg_value, output ready);
endinterface

>>> rtl/mrf_byte_if.sv
// ----------------------------------------------------------------------------
// mrf_byte_if
// frame byte channel: valid/ready with one byte and an end marker
// ----------------------------------------------------------------------------
interface mrf_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       frame_end;

  modport source (output valid, output tx_byte, output frame_end, input ready);
  modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

>>> rtl/mrf_front.sv
// ----------------------------------------------------------------------------
// mrf_front
// takes requests, classifies read/write and lays out the frame body
// ----------------------------------------------------------------------------
module mrf_front (
  mrf_req_if.sink         req,
  input  logic            q_full,
  output mrf_pkg::mrf_push_t push
);
  import mrf_pkg::*;

  mrf_body_t body;

  always_comb begin
    body.slave_addr = req.slave_addr;
    body.reg_addr   = req.reg_addr;
    if (req.func == FUNC_READ) begin
      body.code = CODE_READ;
      body.word = READ_COUNT;
    end else begin
      body.code = CODE_WRITE;
      body.word = req.reg_value;
    end
  end

  assign req.ready  = ~q_full;
  assign push.valid = req.valid & ~q_full;
  assign push.body  = body;

endmodule

>>> rtl/mrf_queue.sv
// ----------------------------------------------------------------------------
// mrf_queue
// short fifo of frame bodies between front and back
// ----------------------------------------------------------------------------
module mrf_queue #(
  parameter int DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  mrf_pkg::mrf_push_t push,
  input  logic               pop,
  output logic               full,
  output mrf_pkg::mrf_head_t head
);
  import mrf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrf_body_t       mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_ptr_nxt = push.valid ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push.valid && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push.valid) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.body;
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.body  = mem_r[rd_ptr_r];

endmodule

>>> rtl/mrf_back.sv
// ----------------------------------------------------------------------------
// mrf_back
// serializes one frame a byte per cycle while out_tx is ready, running the crc alongside
// ----------------------------------------------------------------------------
module mrf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  mrf_pkg::mrf_head_t head,
  output logic               pop,
  mrf_byte_if.source         tx
);
  import mrf_pkg::*;

  logic              busy_r, busy_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BODY_W-1:0] sh_r, sh_nxt;
  logic [15:0]       crc_r, crc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r, out_byte_nxt;
  logic              out_end_r, out_end_nxt;

  logic              adv;
  logic [7:0]        cur_byte;
  logic              last;

  assign adv  = ~out_valid_r | tx.ready;
  assign last = (idx_r == IDX_LAST);
  assign pop  = adv & head.valid & (~busy_r | last);

  always_comb begin
    if (idx_r == IDX_CRC_LO) begin
      cur_byte = crc_r[7:0];
    end else if (last) begin
      cur_byte = crc_r[15:8];
    end else begin
      cur_byte = sh_r[BODY_W-1 -: 8];
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    sh_nxt        = sh_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        out_byte_nxt = cur_byte;
        out_end_nxt  = last;
        idx_nxt      = idx_r + 1'b1;
        sh_nxt       = sh_r << 8;
        if (idx_r < IDX_CRC_LO) begin
          crc_nxt = crc_step(crc_r, cur_byte);
        end
        if (last) begin
          busy_nxt = 1'b0;
        end
      end
      if (pop) begin
        busy_nxt = 1'b1;
        idx_nxt  = '0;
        sh_nxt   = head.body;
        crc_nxt  = CRC_INIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r       <= sh_nxt;
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
  end

  assign tx.valid     = out_valid_r;
  assign tx.tx_byte   = out_byte_r;
  assign tx.frame_end = out_end_r;

endmodule

>>> rtl/modbus_rtu_request_framer.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer
// builds the eight-byte modbus rtu request frame (address, code, register,
// value or count, crc-16 low then high) for each request
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake      payload
//  in_req    in   valid/ready    func, slave_addr, reg_addr, reg_value
//  out_tx    out  valid/ready    tx_byte, frame_end (set on the crc high byte)
//
//  each request yields eight byte transactions, one per cycle when out_tx is
//  ready, so frames of a steady stream of requests follow without a gap;
//  the byte serializer in the back part sets that rate
//  first byte of a request passes queue, shift register and output register
//  rst_n is synchronous and clears the queue and serializer control only
//  out_tx stalls hold the output register; the queue keeps taking requests
//  until it is full
//
module modbus_rtu_request_framer #(
  parameter int QUEUE_DEPTH = mrf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  mrf_req_if.sink    in_req,
  mrf_byte_if.source out_tx
);
  import mrf_pkg::*;

  // front -> queue -> back
  mrf_push_t push;
  mrf_head_t head;
  logic      q_full;
  logic      pop;

  // front: classify the request and lay out the six body bytes
  mrf_front u_front (
    .req    (in_req),
    .q_full (q_full),
    .push   (push)
  );

  // queue decouples request acceptance from byte output
  mrf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .full  (q_full),
    .head  (head)
  );

  // back: byte serializer with running crc and output register; it pops the
  // next body while sending the last byte, so frames follow without a gap
  mrf_back u_back (
    .clk   (clk),
    .rst_n (rst_n),
    .head  (head),
    .pop   (pop),
    .tx    (out_tx)
  );

endmodule

>>> tb/modbus_rtu_request_framer_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_request_framer_test
// self-checking bench for the modbus rtu request framer: requests go in on
// in_req, each accepted request is framed by a local predictor (six body
// bytes plus a bit-serial crc-16/modbus) and every byte on out_tx is checked
// in order against it, under random stalls on both channels
// ----------------------------------------------------------------------------
module modbus_rtu_request_framer_test;
  import mrf_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transaction at all
  localparam int LONG_HOLD      = 64;    // receiver hold-off in pressure test
  localparam int DRAIN_CYCLES   = 20;    // settle time after the last byte

  // one expected frame byte
  typedef struct {
    logic [7:0] tx_byte;
    logic       frame_end;
  } frame_byte_t;

  logic clk;
  logic rst_n;

  mrf_req_if  req_ch ();
  mrf_byte_if tx_ch ();

  modbus_rtu_request_framer uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_tx (tx_ch)
  );

  // bytes still owed by the block, oldest first
  frame_byte_t pending_bytes[$];

  int errors;
  int reads_framed;
  int writes_framed;
  int bytes_checked;
  int idle_cycles;

  // idling knobs, flipped by the test tasks
  bit src_idle_en;
  bit sink_idle_en;
  bit hold_request;   // ask the receiver for one long hold-off

  // 10 unit clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // crc-16/modbus over the six body bytes, one bit at a time, lsb first
  function automatic logic [15:0] modbus_crc(input logic [7:0] body [6]);
    logic [15:0] crc;
    logic        fb;
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int b = 0; b < 8; b++) begin
        fb  = crc[0] ^ body[i][b];
        crc = crc >> 1;
        if (fb) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    return crc;
  endfunction

  // build the expected eight-byte frame for one accepted request
  function automatic void queue_frame(input logic f, input logic [7:0] station,
                                      input logic [15:0] reg_addr,
                                      input logic [15:0] reg_value);
    logic [7:0]  body [6];
    logic [15:0] word;
    logic [15:0] crc;
    frame_byte_t fb;
    // a read always asks for one register, the value field is don't-care
    word    = (f == FUNC_READ) ? READ_COUNT : reg_value;
    body[0] = station;
    body[1] = (f == FUNC_READ) ? CODE_READ : CODE_WRITE;
    body[2] = reg_addr[15:8];
    body[3] = reg_addr[7:0];
    body[4] = word[15:8];
    body[5] = word[7:0];
    crc     = modbus_crc(body);
    for (int i = 0; i < 6; i++) begin
      fb.tx_byte   = body[i];
      fb.frame_end = 1'b0;
      pending_bytes.push_back(fb);
    end
    // crc goes out low byte first, the high byte closes the frame
    fb.tx_byte   = crc[7:0];
    fb.frame_end = 1'b0;
    pending_bytes.push_back(fb);
    fb.tx_byte   = crc[15:8];
    fb.frame_end = 1'b1;
    pending_bytes.push_back(fb);
    if (f == FUNC_READ) begin
      reads_framed++;
    end else begin
      writes_framed++;
    end
  endfunction

  // checker: compare each byte transaction, then predict from the request
  // transaction at the same edge (its bytes cannot show up before next cycles)
  always @(posedge clk) begin
    frame_byte_t want;
    if (rst_n) begin
      if (tx_ch.valid && tx_ch.ready) begin
        if (pending_bytes.size() == 0) begin
          $error("unexpected byte transaction: tx_byte=%02h frame_end=%0b",
                 tx_ch.tx_byte, tx_ch.frame_end);
          errors++;
        end else begin
          want = pending_bytes.pop_front();
          if (tx_ch.tx_byte !== want.tx_byte) begin
            $error("tx_byte mismatch: expected %02h, actual %02h",
                   want.tx_byte, tx_ch.tx_byte);
            errors++;
          end
          if (tx_ch.frame_end !== want.frame_end) begin
            $error("frame_end mismatch: expected %0b, actual %0b",
                   want.frame_end, tx_ch.frame_end);
            errors++;
          end
          bytes_checked++;
        end
      end
      if (req_ch.valid && req_ch.ready) begin
        queue_frame(req_ch.func, req_ch.slave_addr, req_ch.reg_addr,
                    req_ch.reg_value);
      end
    end
  end

  // watchdog: any transaction on either side counts as progress
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (tx_ch.valid && tx_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: ready with random stall bursts, plus one long hold on request
  initial begin
    tx_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        // long stretch with ready low so the request queue fills
        tx_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_request = 1'b0;
      end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
        tx_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        tx_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // offer one request and hold it until accepted, then maybe idle a while
  task automatic send_request(input logic f, input logic [7:0] station,
                              input logic [15:0] reg_addr,
                              input logic [15:0] reg_value);
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.slave_addr <= station;
    req_ch.reg_addr   <= reg_addr;
    req_ch.reg_value  <= reg_value;
    @(posedge clk);
    while (!req_ch.ready) begin
      @(posedge clk);
    end
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      // idle burst; payload wanders meanwhile, which the block must ignore
      req_ch.valid      <= 1'b0;
      req_ch.func       <= 1'($urandom);
      req_ch.slave_addr <= 8'($urandom);
      req_ch.reg_addr   <= 16'($urandom);
      req_ch.reg_value  <= 16'($urandom);
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // field values biased toward the edges of their range
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001 << $urandom_range(0, 15);
      3:       return ~(16'h0001 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_station();
    case ($urandom_range(0, 5))
      0:       return 8'h00;    // broadcast
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // corner requests: extreme fields, both operations, broadcast address,
  // reads with a value that must be ignored
  task automatic test_directed();
    send_request(FUNC_WRITE, 8'h00, 16'h0000, 16'h0000);
    send_request(FUNC_WRITE, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(FUNC_READ,  8'h00, 16'h0000, 16'h0000);
    send_request(FUNC_READ,  8'hFF, 16'hFFFF, 16'hFFFF);
    send_request(FUNC_READ,  8'h01, 16'h0001, 16'hBEEF);
    send_request(FUNC_WRITE, 8'h01, 16'h0001, 16'h0003);
    send_request(FUNC_WRITE, 8'hAA, 16'h5555, 16'hAAAA);
    send_request(FUNC_WRITE, 8'h55, 16'hAAAA, 16'h5555);
    send_request(FUNC_READ,  8'h80, 16'h8000, 16'h0001);
    send_request(FUNC_WRITE, 8'h00, 16'h00FF, 16'hFF00);
    send_request(FUNC_READ,  8'h7F, 16'h7FFF, 16'h8000);
    send_request(FUNC_WRITE, 8'hF7, 16'h0100, 16'h0001);
  endtask

  // back-to-back requests while the receiver holds off
  task automatic test_backpressure();
    src_idle_en  = 1'b0;
    hold_request = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_request(1'($urandom), pick_station(), pick_word(), pick_word());
    end
  endtask

  // bulk random traffic with idling on both sides
  task automatic test_random_traffic(input int count);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    for (int i = 0; i < count; i++) begin
      send_request(1'($urandom), pick_station(), pick_word(), pick_word());
    end
  endtask

  // full rate at the end, no idling anywhere
  task automatic test_full_rate(input int count);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    for (int i = 0; i < count; i++) begin
      send_request(1'($urandom), pick_station(), pick_word(), pick_word());
    end
    req_ch.valid <= 1'b0;
  endtask

  initial begin
    errors        = 0;
    reads_framed  = 0;
    writes_framed = 0;
    bytes_checked = 0;
    idle_cycles   = 0;
    src_idle_en   = 1'b0;
    sink_idle_en  = 1'b0;
    hold_request  = 1'b0;

    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.func       <= FUNC_WRITE;
    req_ch.slave_addr <= 8'h00;
    req_ch.reg_addr   <= 16'h0000;
    req_ch.reg_value  <= 16'h0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_random_traffic(230);
    test_full_rate(20);

    // drain: the watchdog bounds this if bytes stop coming
    while (pending_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("framed %0d write and %0d read requests, %0d bytes compared",
             writes_framed, reads_framed, bytes_checked);
    $display("with random stalls both sides, one long receiver hold-off and a full-rate tail");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
